/* sv/iirl_pkg.sv */
`default_nettype none
package iirl_pkg;

	localparam int IIRL_CAPACITY = 16;

	localparam int OPCODE_W = 3;
	localparam int POS_W    = 4;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_INSERT_AT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_READ_AT    = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} iirl_ctl_t;

endpackage
`default_nettype wire

/* sv/iirl_if.sv */
`default_nettype none
interface iirl_req_if;
	import iirl_pkg::*;
	logic                         valid;
	logic                         ready;
	logic        [OPCODE_W-1:0]   opcode;
	logic        [POS_W-1:0]      position;
	logic signed [WORD_W-1:0]     value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface iirl_rsp_if;
	import iirl_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [WORD_W-1:0]     data;
	logic        [COUNT_W-1:0]    count;
	logic        [STATUS_W-1:0]   status;

	modport source (output valid, data, count, status, input ready);
	modport sink   (input valid, data, count, status, output ready);
endinterface
`default_nettype wire

/* sv/indexed_insert_remove_list.sv */
`default_nettype none
// Channel | Dir | Modport     | Payload
// req     | in  | iirl_req_if | opcode[2:0], position[3:0], value[31:0] signed
// rsp     | out | iirl_rsp_if | data[31:0] signed, count[4:0], status[1:0]
//
// One transaction in, one transaction out. The whole operation is done in
// the cycle of acceptance: every cell of the chain shifts, loads or holds at
// once, and the result is written into the output register at the same edge.
// Throughput is one transaction per cycle; req.ready only drops while a
// result waits in the output register and rsp.ready is low.
// arst_n clears the count and the output valid; the cells are not reset.
module indexed_insert_remove_list #(
	parameter int CAPACITY = iirl_pkg::IIRL_CAPACITY
) (
	input wire logic       clk,
	input wire logic       arst_n,
	iirl_req_if.sink       req,
	iirl_rsp_if.source     rsp
);
	import iirl_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	// Compare width wide enough for both the position field and the count.
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             cnt_next;
	logic                      vld_q;
	logic signed [WORD_W-1:0]  data_q;
	logic [COUNT_W-1:0]        count_q;
	logic [STATUS_W-1:0]       status_q;

	logic                      acc;
	logic                      full;
	logic                      empty;
	logic                      pos_ok;
	logic [IW-1:0]             at;
	logic                      do_ins;
	logic                      do_rem;
	logic                      do_rd;
	logic [STATUS_W-1:0]       status_d;
	iirl_ctl_t                 ctl;

	logic signed [WORD_W-1:0]  cell_q   [CAPACITY];
	logic signed [WORD_W-1:0]  cell_tap [CAPACITY];
	logic signed [WORD_W-1:0]  rd_word;

	assign req.ready = !vld_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign pos_ok = (PW'(req.position) < PW'(cnt_q));

	// Opcode decode: target slot, which shift, and the status.
	always_comb begin
		at       = '0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_rd    = 1'b0;
		status_d = ST_OK;
		unique case (req.opcode)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
				if (req.opcode == OP_PUSH_BACK) begin
					at = IW'(cnt_q);
				end else if (req.opcode == OP_INSERT_AT) begin
					// Position at or past the end appends.
					at = pos_ok ? IW'(req.position) : IW'(cnt_q);
				end
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (req.opcode == OP_POP_BACK) begin
					at = IW'(cnt_q - CW'(1));
				end
				if (empty) begin
					status_d = ST_BAD;
				end else begin
					do_rem = 1'b1;
				end
			end
			OP_REMOVE_AT, OP_READ_AT: begin
				at = IW'(req.position);
				if (!pos_ok) begin
					status_d = ST_BAD;
				end else if (req.opcode == OP_REMOVE_AT) begin
					do_rem = 1'b1;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
				status_d = ST_BAD;
			end
		endcase
	end

	assign ctl.ins = acc && do_ins;
	assign ctl.rem = acc && do_rem;

	always_comb begin
		cnt_next = cnt_q;
		if (do_ins) begin
			cnt_next = cnt_q + CW'(1);
		end else if (do_rem) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	// Chain of cells: each takes its left neighbor on insert and its right
	// neighbor on remove. The end cells see zero beyond the chain.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end
		iirl_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.at    (at),
			.val   (req.value),
			.left  (left_w),
			.right (right_w),
			.q     (cell_q[i]),
			.tap   (cell_tap[i])
		);
	end

	// OR bus over the one-hot cell taps.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_next;
				vld_q <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_q   <= (do_rem || do_rd) ? rd_word : '0;
			count_q  <= COUNT_W'(cnt_next);
			status_q <= status_d;
		end
	end

	assign rsp.valid  = vld_q;
	assign rsp.data   = data_q;
	assign rsp.count  = count_q;
	assign rsp.status = status_q;

endmodule
`default_nettype wire

/* sv/iirl_cell.sv */
`default_nettype none
module iirl_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  wire logic                             clk,
	input  wire iirl_pkg::iirl_ctl_t              ctl,
	input  wire logic [IW-1:0]                    at,
	input  wire logic signed [iirl_pkg::WORD_W-1:0] val,
	input  wire logic signed [iirl_pkg::WORD_W-1:0] left,
	input  wire logic signed [iirl_pkg::WORD_W-1:0] right,
	output logic signed [iirl_pkg::WORD_W-1:0]      q,
	output logic signed [iirl_pkg::WORD_W-1:0]      tap
);
	import iirl_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [WORD_W-1:0] word_q;
	logic                     hit;
	logic                     below;

	assign hit   = (at == MY_IDX);
	assign below = (at < MY_IDX);

	always_ff @(posedge clk) begin
		priority if (ctl.ins && hit) begin
			word_q <= val;
		end else if (ctl.ins && below) begin
			word_q <= left;
		end else if (ctl.rem && (hit || below)) begin
			word_q <= right;
		end else begin
			word_q <= word_q;
		end
	end

	assign q   = word_q;
	// Read port: only the addressed cell puts its word on the OR bus.
	assign tap = hit ? word_q : '0;

endmodule
`default_nettype wire

/* sv/iirl_checker.sv */
`default_nettype none
module iirl_checker #(
	parameter int CAPACITY = iirl_pkg::IIRL_CAPACITY
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                req_ready,
	input wire logic                                rsp_valid,
	input wire logic                                rsp_ready,
	input wire logic signed [iirl_pkg::WORD_W-1:0]   rsp_data,
	input wire logic [iirl_pkg::COUNT_W-1:0]         rsp_count,
	input wire logic [iirl_pkg::STATUS_W-1:0]        rsp_status
);
	import iirl_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
			&& $stable(rsp_count) && $stable(rsp_status))
		else $error("rsp changed while stalled");

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("req taken while result pending");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == CAP_CNT && rsp_data == '0)
		else $error("full status with wrong count or data");

	a_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_BAD |-> rsp_data == '0)
		else $error("error status with nonzero data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_FULL
			|| rsp_status == ST_BAD)
		else $error("unknown status code");

endmodule

bind indexed_insert_remove_list iirl_checker #(
	.CAPACITY (CAPACITY)
) u_iirl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data),
	.rsp_count  (rsp.count),
	.rsp_status (rsp.status)
);
`default_nettype wire

/* bench/testbench.sv */
`default_nettype none
// Self-checking bench for indexed_insert_remove_list.
// A directed table runs the empty, full and bad-index cases first. The random
// phases after it lean toward growing, shrinking or mixing the list, so that
// the full and empty edges are hit many times. Every accepted request is run
// through a local list model. The predicted response is queued and then
// compared field by field with each response transaction.
module testbench;
	import iirl_pkg::*;

	// Opcode value with no operation behind it; the block must reject it.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

	localparam int DEPTH       = IIRL_CAPACITY;
	localparam int TOTAL_ITEMS = 1050;
	localparam int LONG_HOLD   = 60;     // cycles of rsp.ready low in the long hold-off
	localparam int SETTLE      = 4;      // wait after the final drain before the summary

	typedef struct packed {
		logic signed [WORD_W-1:0]   data;
		logic        [COUNT_W-1:0]  count;
		logic        [STATUS_W-1:0] status;
	} list_result_t;

	// One row of the directed table. A row with rep > 1 is sent rep times, and
	// the value steps up by one on each repeat. A row with typed set carries
	// its response inline. All other rows take the response of the list model.
	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic [POS_W-1:0]    pos;
		logic [WORD_W-1:0]   val;
		int                  rep;
		bit                  typed;
		list_result_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	iirl_req_if req();
	iirl_rsp_if rsp();

	indexed_insert_remove_list #(
		.CAPACITY(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// List model state. Only the entries below store_len are meaningful.
	logic [WORD_W-1:0] word_store [DEPTH];
	int                store_len = 0;

	list_result_t expected_results[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  full_drops     = 0;
	int  rejects        = 0;
	int  drains         = 0;
	int  long_holds     = 0;
	bit  quiet          = 1'b0;  // both sides stop idling while set
	bit  hold_request   = 1'b0;  // sender asks the response side for a long hold-off

	// Directed table: empty list first, then fill up to capacity, then the full
	// list, then removals at both ends and in the middle.
	stim_row_t directed_rows [17] = '{
		'{OP_POP_BACK,   4'd0,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_BAD}},
		'{OP_REMOVE_AT,  4'd0,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_BAD}},
		'{OP_READ_AT,    4'd15, 32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_BAD}},
		'{OP_UNUSED,     4'd9,  32'h1234_5678, 1,  1'b1, '{32'h0000_0000, 5'd0,  ST_BAD}},
		'{OP_PUSH_BACK,  4'd0,  32'h7FFF_FFFF, 1,  1'b1, '{32'h0000_0000, 5'd1,  ST_OK}},
		'{OP_PUSH_FRONT, 4'd0,  32'h8000_0000, 1,  1'b1, '{32'h0000_0000, 5'd2,  ST_OK}},
		// position past the count appends at the back
		'{OP_INSERT_AT,  4'd15, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0000_0000, 5'd3,  ST_OK}},
		'{OP_READ_AT,    4'd0,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd3,  ST_OK}},
		// index equal to the count is out of range
		'{OP_READ_AT,    4'd3,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 5'd3,  ST_BAD}},
		'{OP_INSERT_AT,  4'd1,  32'h0000_0100, 13, 1'b0, '0},
		'{OP_PUSH_BACK,  4'd0,  32'h5A5A_5A5A, 1,  1'b1, '{32'h0000_0000, 5'd16, ST_FULL}},
		'{OP_PUSH_FRONT, 4'd0,  32'hA5A5_A5A5, 1,  1'b1, '{32'h0000_0000, 5'd16, ST_FULL}},
		'{OP_INSERT_AT,  4'd8,  32'h0F0F_0F0F, 1,  1'b1, '{32'h0000_0000, 5'd16, ST_FULL}},
		'{OP_READ_AT,    4'd15, 32'h0000_0000, 1,  1'b0, '0},
		'{OP_REMOVE_AT,  4'd5,  32'h0000_0000, 1,  1'b0, '0},
		'{OP_POP_FRONT,  4'd0,  32'h0000_0000, 1,  1'b1, '{32'h8000_0000, 5'd14, ST_OK}},
		'{OP_POP_BACK,   4'd0,  32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, 5'd13, ST_OK}}
	};

	// Apply one request to the list model and return the response it gives.
	function automatic list_result_t list_apply(input logic [OPCODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] val);
		list_result_t res;
		int           slot;
		int           i;
		bit           closing;
		res     = '0;
		slot    = 0;
		closing = 1'b0;
		res.status = ST_OK;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
				if (store_len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (op == OP_PUSH_BACK)
						slot = store_len;
					else if (op == OP_PUSH_FRONT)
						slot = 0;
					else
						slot = (int'(pos) >= store_len) ? store_len : int'(pos);
					// open a hole: later entries move up one place
					for (i = store_len; i > slot; i--)
						word_store[i] = word_store[i-1];
					word_store[slot] = val;
					store_len++;
				end
			end
			OP_POP_BACK: begin
				if (store_len == 0) res.status = ST_BAD;
				else begin slot = store_len - 1; closing = 1'b1; end
			end
			OP_POP_FRONT: begin
				if (store_len == 0) res.status = ST_BAD;
				else begin slot = 0; closing = 1'b1; end
			end
			OP_REMOVE_AT: begin
				if (int'(pos) >= store_len) res.status = ST_BAD;
				else begin slot = int'(pos); closing = 1'b1; end
			end
			OP_READ_AT: begin
				if (int'(pos) >= store_len) res.status = ST_BAD;
				else res.data = word_store[pos];
			end
			default: res.status = ST_BAD;
		endcase
		if (closing) begin
			// take the entry out, later entries move down one place
			res.data = word_store[slot];
			for (i = slot; i + 1 < store_len; i++)
				word_store[i] = word_store[i+1];
			store_len--;
		end
		res.count = COUNT_W'(store_len);
		return res;
	endfunction

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// grow_pct sets the share of pushes and inserts among ops that change the count
	function automatic logic [OPCODE_W-1:0] pick_op(input int grow_pct);
		int r;
		int pair;
		bit grow_it;
		r       = $urandom_range(0, 99);
		pair    = $urandom_range(0, 2);
		grow_it = ($urandom_range(0, 99) < grow_pct);
		if (r < 2) return OP_UNUSED;
		if (r < 14) return OP_READ_AT;
		case (pair)
			0:       return grow_it ? OP_PUSH_BACK  : OP_POP_BACK;
			1:       return grow_it ? OP_PUSH_FRONT : OP_POP_FRONT;
			default: return grow_it ? OP_INSERT_AT  : OP_REMOVE_AT;
		endcase
	endfunction

	// Half the positions fall close to the current count, where the in-range
	// and out-of-range cases meet.
	function automatic logic [POS_W-1:0] pick_pos();
		int p;
		if ($urandom_range(0, 1) == 0)
			return POS_W'($urandom_range(0, DEPTH - 1));
		p = store_len - 1 + $urandom_range(0, 2);
		if (p < 0) p = 0;
		if (p > DEPTH - 1) p = DEPTH - 1;
		return POS_W'(p);
	endfunction

	function automatic logic [WORD_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 39);
		case (r)
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
	endtask

	// Offer one request, wait for the handshake, then queue its expected
	// response. valid stays high into the next request unless an idle gap is
	// drawn, so back-to-back transactions get a single NBA on valid per step.
	task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] val, input bit typed, input list_result_t want);
		list_result_t model_out;
		int           gap;
		req.valid    <= 1'b1;
		req.opcode   <= op;
		req.position <= pos;
		req.value    <= val;
		do @(posedge clk); while (!req.ready);
		model_out = list_apply(op, pos, val);
		expected_results.push_back(typed ? want : model_out);
		items_sent++;
		if (model_out.status == ST_FULL) full_drops++;
		if (model_out.status == ST_BAD) rejects++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pauses until every queued response has come back. The loop waits on
	// the clock before it checks the queue, so the next request never lands in the same step.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Request side: reset, directed table, then random phases.
	initial begin : req_driver
		int phase_no;
		int phase_len;
		int grow_pct;
		int k;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.opcode   <= OP_PUSH_BACK;
		req.position <= '0;
		req.value    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			for (k = 0; k < directed_rows[r].rep; k++)
				send_op(directed_rows[r].op, directed_rows[r].pos,
					directed_rows[r].val + k, directed_rows[r].typed, directed_rows[r].want);
		end
		drain();
		drains++;

		// Phases cycle through growing, shrinking and mixed traffic. Every
		// fourth phase runs without idling on either side.
		phase_no = 0;
		while (items_sent < TOTAL_ITEMS) begin
			phase_len = $urandom_range(40, 110);
			case (phase_no % 3)
				0:       grow_pct = 75;
				1:       grow_pct = 25;
				default: grow_pct = 50;
			endcase
			quiet = (phase_no % 4 == 3);
			// long hold-off on the response side while requests keep coming:
			// the output register fills and req.ready must drop
			if (phase_no == 2) hold_request = 1'b1;
			for (k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++)
				send_op(pick_op(grow_pct), pick_pos(), pick_value(), 1'b0, '0);
			if (phase_no % 5 == 4) begin
				drain();
				drains++;
			end
			phase_no++;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d transactions in %0d random phases: %0d pushes dropped on a full list,",
			items_sent, phase_no, full_drops);
		$display("%0d rejected as empty, bad index or unused opcode; %0d drains, %0d long hold-offs.",
			rejects, drains, long_holds);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Response side: random stalls, plus one long hold-off counted here.
	initial begin : rsp_sink
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_holds++;
			end else begin
				stall = quiet ? 0 : pick_gap();
				if (stall == 0) begin
					rsp.ready <= 1'b1;
					@(posedge clk);
				end else begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// Compare each response transaction with the oldest expected response.
	always @(posedge clk) begin : rsp_check
		list_result_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected response", rsp.data, '0);
			end else begin
				want = expected_results.pop_front();
				if (rsp.data !== want.data)
					report_mismatch("data", rsp.data, want.data);
				if (rsp.count !== want.count)
					report_mismatch("count", 32'(rsp.count), 32'(want.count));
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
			end
		end
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
